// File: rtl/core/tfr_pkg.sv
// ---------------------------------------------------------------------------
// Telecommand frame reassembler package
// Shared widths, operation codes and the status record passed between the
// header/count logic and the top level.
// ---------------------------------------------------------------------------
package tfr_pkg;

    localparam int DATA_W          = 8;
    localparam int COUNT_W         = 9;
    localparam int HEADER_BYTES    = 2;
    localparam int COUNT_MAX       = 511;
    localparam int BLOCK_BYTES_DEF = 7;
    localparam int STORE_BYTES_DEF = 255;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    typedef struct packed {
        logic              ready;
        logic [DATA_W-1:0] msg_len;
        logic [DATA_W-1:0] frame_seq;
        logic [DATA_W-1:0] ack_seq;
        logic              dropped;
    } t_status;

endpackage

// File: rtl/core/tfr_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read and read enable.
// ---------------------------------------------------------------------------
module tfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tfr_parse.sv
// ---------------------------------------------------------------------------
// Frame header and byte count tracking
// Holds the frame counters, header fields and ready flag, and produces the
// message store write for each taken message byte that fits in the store.
// ---------------------------------------------------------------------------
module tfr_parse
    import tfr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [1:0]                     i_opcode,
    input  logic [DATA_W-1:0]              i_block_byte,
    output logic                           o_we,
    output logic [$clog2(STORE_BYTES)-1:0] o_waddr,
    output t_status                        o_status
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int BW = $clog2(BLOCK_BYTES + 1);
    localparam logic [BW-1:0]      BlockLim = BW'(BLOCK_BYTES);
    localparam logic [COUNT_W-1:0] StoreLim = COUNT_W'(STORE_BYTES);
    localparam logic [COUNT_W-1:0] CountTop = COUNT_W'(COUNT_MAX);
    localparam logic [COUNT_W-1:0] HdrLen   = COUNT_W'(HEADER_BYTES);

    logic [COUNT_W-1:0] r_fc, n_fc;
    logic [BW-1:0]      r_blk, n_blk;
    logic [DATA_W-1:0]  r_total, n_total;
    logic [DATA_W-1:0]  r_seq, n_seq;
    logic [DATA_W-1:0]  r_ack, n_ack;
    logic               r_ready, n_ready;

    logic               take;
    logic [COUNT_W-1:0] fc_inc;
    logic [COUNT_W-1:0] pos;
    logic [BW-1:0]      blk_inc;

    assign take    = i_accept && (i_opcode == OP_BYTE) && !r_ready;
    assign fc_inc  = (r_fc == CountTop) ? r_fc : r_fc + COUNT_W'(1);
    assign blk_inc = r_blk + BW'(1);
    assign pos     = r_fc - HdrLen;

    always_comb begin
        n_fc    = r_fc;
        n_blk   = r_blk;
        n_total = r_total;
        n_seq   = r_seq;
        n_ack   = r_ack;
        n_ready = r_ready;
        if (take) begin
            if (r_fc == COUNT_W'(0)) begin
                n_total = i_block_byte;
            end else if (r_fc == COUNT_W'(1)) begin
                n_seq = i_block_byte;
            end
            n_fc  = fc_inc;
            n_blk = blk_inc;
            if (blk_inc >= BlockLim) begin
                n_blk = '0;
                // Frame complete only on a whole block boundary.
                if (fc_inc >= {1'b0, n_total}) begin
                    n_ready = 1'b1;
                    n_ack   = n_seq;
                    n_fc    = '0;
                end
            end
        end else if (i_accept && (i_opcode == OP_RELEASE)) begin
            n_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc    <= '0;
            r_blk   <= '0;
            r_total <= '0;
            r_seq   <= '0;
            r_ack   <= '0;
            r_ready <= 1'b0;
        end else begin
            r_fc    <= n_fc;
            r_blk   <= n_blk;
            r_total <= n_total;
            r_seq   <= n_seq;
            r_ack   <= n_ack;
            r_ready <= n_ready;
        end
    end

    assign o_we    = take && (r_fc >= HdrLen) && (pos < StoreLim);
    assign o_waddr = pos[AW-1:0];

    assign o_status.ready     = n_ready;
    assign o_status.msg_len   = (n_total >= DATA_W'(HEADER_BYTES))
                                ? n_total - DATA_W'(HEADER_BYTES) : '0;
    assign o_status.frame_seq = n_seq;
    assign o_status.ack_seq   = n_ack;
    assign o_status.dropped   = i_accept && (i_opcode == OP_BYTE) && r_ready;

    // A ready frame always leaves the byte count cleared.
    a_ready_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_fc == '0))
        else $error("frame count not cleared while frame ready");

    a_block_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blk < BlockLim)
        else $error("block byte count out of range");

    a_ready_sets_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ready) |-> (r_ack == $past(r_seq) || r_ack == $past(n_seq)))
        else $error("acknowledge sequence not taken on completion");

endmodule

// File: rtl/core/telecommand_frame_reassembler.sv
// ---------------------------------------------------------------------------
// Telecommand frame reassembler
// Rebuilds telecommand frames from code block bytes and serves message reads.
// ---------------------------------------------------------------------------
// The block takes one beat per clock cycle while o_in_stall is low, and returns
// exactly one result beat for each input beat, through stage one and the
// output register. The message store is a synchronous RAM with one write and
// one read port and a registered read, so a read beat's data is available in
// the cycle after it is accepted and is then placed in the output register.
// Code block bytes write the store in the cycle they are accepted, so a later
// read always sees them. Frame header fields, counts and the ready flag live
// in registers and are updated at acceptance; every result shows the state
// after its own beat. The store has no reset and no clearing pass: reading
// an entry never written since reset returns an undefined byte. Reads at or
// beyond the store depth return zero.
// ---------------------------------------------------------------------------
module telecommand_frame_reassembler
    import tfr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [DATA_W-1:0] i_block_byte,
    input  logic [DATA_W-1:0] i_read_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_frame_ready,
    output logic [DATA_W-1:0] o_message_length,
    output logic [DATA_W-1:0] o_seq_number,
    output logic [DATA_W-1:0] o_ack_sequence,
    output logic              o_byte_dropped
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [DATA_W:0] ReadLim = (DATA_W + 1)'(STORE_BYTES);

    // Stage one: the beat has been accepted and its store read is in flight.
    logic              r_s1_valid;
    logic              r_s1_read;
    t_status           r_s1_status;
    // Stage two: the output register.
    logic              r_s2_valid;
    logic [DATA_W-1:0] r_s2_data;
    t_status           r_s2_status;

    logic              accept;
    logic              s1_adv;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;
    t_status           status;

    // Stage one moves on whenever the output register is free or draining.
    assign s1_adv     = !r_s2_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    // Out-of-range reads never touch the store and return zero.
    assign ram_re = accept && (i_opcode == OP_READ) && ({1'b0, i_read_index} < ReadLim);

    tfr_parse #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .STORE_BYTES (STORE_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_block_byte (i_block_byte),
        .o_we         (ram_we),
        .o_waddr      (ram_waddr),
        .o_status     (status)
    );

    tfr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_block_byte),
        .i_re    (ram_re),
        .i_raddr (i_read_index[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Payload registers carry no reset; only the valid bits are cleared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (r_s1_valid && s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_s2_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_s1_read   <= ram_re;
            r_s1_status <= status;
        end
        if (r_s1_valid && s1_adv) begin
            r_s2_data   <= r_s1_read ? ram_rdata : '0;
            r_s2_status <= r_s1_status;
        end
    end

    assign o_out_valid      = r_s2_valid;
    assign o_read_data      = r_s2_data;
    assign o_frame_ready    = r_s2_status.ready;
    assign o_message_length = r_s2_status.msg_len;
    assign o_seq_number     = r_s2_status.frame_seq;
    assign o_ack_sequence   = r_s2_status.ack_seq;
    assign o_byte_dropped   = r_s2_status.dropped;

    // The input is only held back by a full first stage.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty first stage");

    // A beat never both writes and reads the store.
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store written and read by one beat");

    // An accepted beat always lands in stage one.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted beat lost");

endmodule

// File: tb/tfr_frame_checker.sv
// ---------------------------------------------------------------------------
// Telecommand frame reassembler result checker
// Watches both channels of the reassembler, predicts the status beat owed
// for every accepted input beat and compares each output beat field by field.
// ---------------------------------------------------------------------------
module tfr_frame_checker
    import tfr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [1:0]             i_opcode,
    input  logic [DATA_W-1:0]      i_block_byte,
    input  logic [DATA_W-1:0]      i_read_index,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [DATA_W-1:0]      i_read_data,
    input  logic                   i_frame_ready,
    input  logic [DATA_W-1:0]      i_message_length,
    input  logic [DATA_W-1:0]      i_seq_number,
    input  logic [DATA_W-1:0]      i_ack_sequence,
    input  logic                   i_byte_dropped,
    output int unsigned            o_fail_count,
    output int unsigned            o_pending,
    output int unsigned            o_compared,
    output logic                   o_frame_ready,
    output logic                   o_frame_start,
    output logic [STORE_BYTES-1:0] o_store_written
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        t_status           status;
    } t_reply;

    logic [DATA_W-1:0]      store_copy [STORE_BYTES];
    logic [STORE_BYTES-1:0] stored_mask = '0;
    logic [COUNT_W-1:0]     byte_count  = '0;
    int unsigned            block_pos   = 0;
    logic [DATA_W-1:0]      frame_len   = '0;
    logic [DATA_W-1:0]      frame_seq   = '0;
    logic [DATA_W-1:0]      acked_seq   = '0;
    logic                   frame_done  = 1'b0;
    t_reply                 awaited_replies [$];
    int unsigned            fails       = 0;
    int unsigned            compared    = 0;

    // Header bytes first, then message bytes; completion is judged only at
    // the end of a code block.
    function automatic void absorb_byte(logic [DATA_W-1:0] b);
        int pos;
        if (byte_count == 0) begin
            frame_len = b;
        end else if (byte_count == 1) begin
            frame_seq = b;
        end else begin
            pos = int'(byte_count) - HEADER_BYTES;
            if (pos < STORE_BYTES) begin
                store_copy[pos]  = b;
                stored_mask[pos] = 1'b1;
            end
        end
        if (byte_count < COUNT_MAX) byte_count++;
        block_pos++;
        if (block_pos >= BLOCK_BYTES) begin
            block_pos = 0;
            if (byte_count >= frame_len) begin
                frame_done = 1'b1;
                acked_seq  = frame_seq;
                byte_count = '0;
            end
        end
    endfunction

    function automatic t_reply apply_beat(logic [1:0] op, logic [DATA_W-1:0] b,
                                          logic [DATA_W-1:0] idx);
        t_reply r;
        r = '0;
        case (op)
            OP_BYTE: begin
                if (frame_done) r.status.dropped = 1'b1;
                else absorb_byte(b);
            end
            OP_READ: begin
                if (idx < STORE_BYTES) r.read_data = store_copy[idx];
            end
            OP_RELEASE: begin
                frame_done = 1'b0;
            end
            default: ;
        endcase
        r.status.ready     = frame_done;
        r.status.msg_len   = (frame_len >= HEADER_BYTES) ?
                             DATA_W'(frame_len - HEADER_BYTES) : '0;
        r.status.frame_seq = frame_seq;
        r.status.ack_seq   = acked_seq;
        return r;
    endfunction

    function automatic void compare_field(string name, int unsigned want,
                                          int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            byte_count = '0;
            block_pos  = 0;
            frame_len  = '0;
            frame_seq  = '0;
            acked_seq  = '0;
            frame_done = 1'b0;
            awaited_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    $error("result beat arrived with no prediction waiting");
                    fails++;
                end else begin
                    want = awaited_replies.pop_front();
                    compare_field("read_data", want.read_data, i_read_data);
                    compare_field("frame_ready", want.status.ready, i_frame_ready);
                    compare_field("message_length", want.status.msg_len,
                                  i_message_length);
                    compare_field("seq_number", want.status.frame_seq,
                                  i_seq_number);
                    compare_field("ack_sequence", want.status.ack_seq, i_ack_sequence);
                    compare_field("byte_dropped", want.status.dropped, i_byte_dropped);
                    compared++;
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_replies.push_back(apply_beat(i_opcode, i_block_byte,
                                                     i_read_index));
        end
        o_fail_count    <= fails;
        o_pending       <= awaited_replies.size();
        o_compared      <= compared;
        o_frame_ready   <= frame_done;
        o_frame_start   <= (byte_count == 0) && (block_pos == 0);
        o_store_written <= stored_mask;
    end

endmodule

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// Telecommand frame reassembler testbench
// Drives code block bytes, message reads, releases and idle operations into
// the reassembler, mostly as whole frames with random content, and leaves
// prediction and comparison to the checker placed beside the block.
// ---------------------------------------------------------------------------
module tb_top;
    import tfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLK        = BLOCK_BYTES_DEF;
    localparam int STORE      = STORE_BYTES_DEF;
    localparam int BEAT_GOAL  = 1550;
    localparam int IDLE_PCT   = 18;
    // The sender never idles while its beat count lies in this window.
    localparam int QUIET_FROM = 600;
    localparam int QUIET_TO   = 900;
    // The receiver holds off completely while its cycle count lies from HOLD_AT up
    // to HOLD_AT + HOLD_LEN, and never stalls in the window that follows later on.
    localparam int HOLD_AT    = 800;
    localparam int HOLD_LEN   = 250;
    localparam int CALM_FROM  = 1400;
    localparam int CALM_TO    = 2000;
    localparam int DRAIN      = 8;
    localparam int STUCK_MAX  = 2000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [1:0]        opcode       = OP_NOP;
    logic [DATA_W-1:0] block_byte   = '0;
    logic [DATA_W-1:0] read_index   = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [DATA_W-1:0] read_data;
    logic              frame_ready;
    logic [DATA_W-1:0] message_length;
    logic [DATA_W-1:0] seq_number;
    logic [DATA_W-1:0] ack_sequence;
    logic              byte_dropped;

    int unsigned       fail_count;
    int unsigned       pending;
    int unsigned       compared;
    logic              chk_ready;
    logic              chk_frame_start;
    logic [STORE-1:0]  chk_written;

    int unsigned       beats_sent   = 0;
    int unsigned       frames_sent  = 0;
    int unsigned       rx_cycle     = 0;
    int unsigned       stuck_cycles = 0;

    wire in_acc  = in_valid && !in_stall;
    wire out_acc = out_valid && !out_stall;

    initial begin
        forever #5 clk = ~clk;
    end

    telecommand_frame_reassembler #(
        .BLOCK_BYTES(BLK),
        .STORE_BYTES(STORE)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_opcode        (opcode),
        .i_block_byte    (block_byte),
        .i_read_index    (read_index),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_read_data     (read_data),
        .o_frame_ready   (frame_ready),
        .o_message_length(message_length),
        .o_seq_number    (seq_number),
        .o_ack_sequence  (ack_sequence),
        .o_byte_dropped  (byte_dropped)
    );

    tfr_frame_checker #(
        .BLOCK_BYTES(BLK),
        .STORE_BYTES(STORE)
    ) u_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_opcode        (opcode),
        .i_block_byte    (block_byte),
        .i_read_index    (read_index),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_read_data     (read_data),
        .i_frame_ready   (frame_ready),
        .i_message_length(message_length),
        .i_seq_number    (seq_number),
        .i_ack_sequence  (ack_sequence),
        .i_byte_dropped  (byte_dropped),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_compared      (compared),
        .o_frame_ready   (chk_ready),
        .o_frame_start   (chk_frame_start),
        .o_store_written (chk_written)
    );

    // The receiver keeps its own cycle count. It stalls at random for most of
    // the run, but holds off completely for one long stretch so that the block
    // fills up and has to stall its input, and later runs a calm stretch with
    // no stalls at all.
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_cycle  <= 0;
            out_stall <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN) begin
                out_stall <= 1'b1;
            end else if (rx_cycle >= CALM_FROM && rx_cycle < CALM_TO) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // The watchdog counts cycles in which neither channel moves a beat. Any
    // correct run stays far below the limit, the long hold-off included.
    always @(posedge clk) begin
        if (!rst_n || in_acc || out_acc) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_MAX) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offers one beat, possibly after a few idle cycles, and returns at the
    // clock edge where it is accepted. The payload is held while stalled.
    task automatic put(input logic [1:0] op, input logic [DATA_W-1:0] b,
                       input logic [DATA_W-1:0] idx);
        int pct;
        pct = (beats_sent >= QUIET_FROM && beats_sent < QUIET_TO) ? 0 : IDLE_PCT;
        while ($urandom_range(99) < pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        block_byte <= b;
        read_index <= idx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    // Drops valid for one cycle, so that the checker's view of the frame state
    // has caught up with every beat offered so far.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Chooses a read position in the given range that is known to hold a
    // written byte. The checker's map of written entries may lag by one beat,
    // which only ever makes it more cautious. When no written entry turns up,
    // the index beyond the store is used, which must read back as zero.
    function automatic logic [DATA_W-1:0] pick_index(int lo, int hi);
        int k;
        for (int t = 0; t < 4; t++) begin
            k = $urandom_range(hi, lo);
            if (k >= STORE) return DATA_W'(STORE);
            if (chk_written[k]) return DATA_W'(k);
        end
        return DATA_W'(STORE);
    endfunction

    task automatic random_beat();
        logic [1:0] op;
        op = 2'($urandom_range(3));
        put(op, DATA_W'($urandom),
            (op == OP_READ) ? pick_index(0, 255) : DATA_W'($urandom));
    endtask

    // Releases any waiting frame and feeds filler bytes until the block sits
    // at the start of a frame, so that a new header lands where it should.
    task automatic realign();
        settle();
        while (chk_ready || !chk_frame_start) begin
            if (chk_ready) put(OP_RELEASE, DATA_W'($urandom), DATA_W'($urandom));
            else put(OP_BYTE, DATA_W'($urandom), DATA_W'($urandom));
            settle();
        end
    endtask

    // Sends one whole frame: the length byte, the sequence byte and body
    // bytes up to the code block in which the length is reached. Now and then
    // other operations are slipped in, or the frame is abandoned half way.
    // Afterwards some of its bytes are read back, a few bytes may be offered
    // while it is still unreleased, and it is usually released.
    task automatic send_frame(input int len, input logic [DATA_W-1:0] seq_no);
        int n;
        n = (len <= BLK) ? BLK : ((len + BLK - 1) / BLK) * BLK;
        put(OP_BYTE, DATA_W'(len), DATA_W'($urandom));
        put(OP_BYTE, seq_no, DATA_W'($urandom));
        for (int i = 2; i < n; i++) begin
            if ($urandom_range(99) < 4) random_beat();
            if ($urandom_range(999) < 5) return;
            put(OP_BYTE, DATA_W'($urandom), DATA_W'($urandom));
        end
        frames_sent++;
        repeat ($urandom_range(4)) put(OP_READ, DATA_W'($urandom), pick_index(0, n - 3));
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(2, 1)) put(OP_BYTE, DATA_W'($urandom), DATA_W'($urandom));
        if ($urandom_range(99) < 90) put(OP_RELEASE, DATA_W'($urandom), DATA_W'($urandom));
    endtask

    initial begin
        int len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: idle and release with nothing ready, a read past
        // the end of the store, then a frame shorter than one code block whose
        // header and filler bytes take the extreme values.
        put(OP_NOP, 8'h00, 8'h00);
        put(OP_RELEASE, 8'h00, 8'h00);
        put(OP_READ, 8'h00, 8'hFF);
        put(OP_BYTE, 8'h00, 8'h00);
        put(OP_BYTE, 8'hFF, 8'h00);
        put(OP_BYTE, 8'h00, 8'h00);
        put(OP_BYTE, 8'hFF, 8'h00);
        put(OP_BYTE, 8'h55, 8'h00);
        put(OP_BYTE, 8'hAA, 8'h00);
        put(OP_BYTE, 8'h01, 8'h00);
        // The frame is complete and unreleased, so this byte must be dropped.
        put(OP_BYTE, 8'h80, 8'h00);
        // Filler bytes of the short frame sit at message positions 0 to 4.
        put(OP_READ, 8'h00, 8'h00);
        put(OP_READ, 8'hFF, 8'h04);
        put(OP_RELEASE, 8'hFF, 8'hFF);
        put(OP_RELEASE, 8'hFF, 8'hFF);
        put(OP_NOP, 8'hFF, 8'hFF);

        // A frame of the greatest length is offered; unless it is abandoned half way,
        // it runs past the end of the store and leaves every entry written.
        realign();
        send_frame(255, DATA_W'($urandom));

        // Random part: whole frames with random lengths and content, mostly
        // short, with bursts of unrelated beats in between.
        while (beats_sent < BEAT_GOAL) begin
            realign();
            if ($urandom_range(99) < 8) len = $urandom_range(255, 200);
            else len = $urandom_range(40, 0);
            send_frame(len, DATA_W'($urandom));
            if ($urandom_range(99) < 15) repeat ($urandom_range(6, 1)) random_beat();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Covered %0d input beats in %0d complete frames; %0d results compared,",
                 beats_sent, frames_sent, compared);
        $display("including a %0d-cycle output hold-off with the input backed up.",
                 HOLD_LEN);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/tfr_pkg.sv
rtl/core/tfr_ram.sv
rtl/core/tfr_parse.sv
rtl/core/telecommand_frame_reassembler.sv
tb/tfr_frame_checker.sv
tb/tb_top.sv
